>>> rtl/bmc_pkg.sv
// Shared constants, types and helpers for the plus-shaped binary morphology filter.
package bmc_pkg;

    // Frame limits
    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int MODE_W     = 2;

    // Counter and dimension widths
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int ROW_W = $clog2(MAX_HEIGHT + 2);

    // Delay line lengths: line A spans one row plus one pixel, line B one row
    localparam int LINE_A = MAX_WIDTH + 1;
    localparam int LINE_B = MAX_WIDTH;

    // Output queue
    localparam int OUTQ_DEPTH = 2;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd2;

    // Operation modes
    localparam logic [MODE_W-1:0] MODE_ERODE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DILATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_OPEN   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_CLOSE  = 2'd3;

    // Request kinds
    localparam logic REQ_PIXEL = 1'b0;
    localparam logic REQ_FLUSH = 1'b1;

    // Item offered to one filter stage
    typedef struct packed {
        logic data_valid;
        logic flush_valid;
        logic data;
    } t_stage_in;

    // Status and result of one filter stage
    typedef struct packed {
        logic produce;
        logic value;
        logic last;
        logic done;
    } t_stage_out;

    // Result transaction
    typedef struct packed {
        logic pixel;
        logic last;
    } t_result;

    // Clamp a written width: zero reads as one, large values saturate
    function automatic logic [WID_W-1:0] clamp_width(input logic [CFG_DATA_W-1:0] v);
        if (v == '0) begin
            return WID_W'(1);
        end else if (32'(v) > MAX_WIDTH) begin
            return WID_W'(MAX_WIDTH);
        end else begin
            return WID_W'(v);
        end
    endfunction

    // Clamp a written height the same way
    function automatic logic [HGT_W-1:0] clamp_height(input logic [CFG_DATA_W-1:0] v);
        if (v == '0) begin
            return HGT_W'(1);
        end else if (32'(v) > MAX_HEIGHT) begin
            return HGT_W'(MAX_HEIGHT);
        end else begin
            return HGT_W'(v);
        end
    endfunction

endpackage

>>> rtl/bmc_cell.sv
// One-bit delay line cell: takes its neighbor's bit, or the new pixel at the insert point.
module bmc_cell (
    input  logic i_clk,
    input  logic i_shift,
    input  logic i_insert,
    input  logic i_new,
    input  logic i_next,
    output logic o_bit
);

    logic r_bit;
    logic n_bit;

    // Select the incoming bit
    always_comb begin
        n_bit = i_insert ? i_new : i_next;
    end

    // Advance on every stage push
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_bit <= n_bit;
        end
    end

    assign o_bit = r_bit;

endmodule

>>> rtl/bmc_stage.sv
// One plus-shaped erosion/dilation stage: two chains of cells as row buffers and a raster counter.
module bmc_stage
    import bmc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_restart,
    input  logic [WID_W-1:0] i_width,
    input  logic [HGT_W-1:0] i_height,
    input  logic             i_dilate,
    input  t_stage_in        i_item,
    output t_stage_out       o_res
);

    logic [COL_W-1:0]  r_col;
    logic [COL_W-1:0]  n_col;
    logic [ROW_W-1:0]  r_row;
    logic [ROW_W-1:0]  n_row;

    logic [LINE_A-1:0] w_a;
    logic [LINE_A-1:0] w_a_next;
    logic [LINE_A-1:0] w_ins_a;
    logic [LINE_B-1:0] w_b;
    logic [LINE_B-1:0] w_b_next;
    logic [LINE_B-1:0] w_ins_b;

    logic [WID_W-1:0]  w_col_inc;
    logic [ROW_W-1:0]  w_h_ext;
    logic              w_row_end;
    logic              w_filling;
    logic              w_draining;
    logic              w_push;
    logic              w_left_ok;
    logic              w_right_ok;
    logic              w_up_ok;
    logic              w_below_ok;
    logic              w_ero;
    logic              w_dil;

    // Line A: insert at cell width, so cell 1 is one row back and cells 0/2 its neighbors
    for (genvar j = 0; j < LINE_A; j++) begin : g_line_a
        assign w_ins_a[j] = (i_width == WID_W'(j));
        if (j == LINE_A - 1) begin : g_end
            assign w_a_next[j] = i_item.data;
        end else begin : g_mid
            assign w_a_next[j] = w_a[j + 1];
        end
        bmc_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (w_push),
            .i_insert (w_ins_a[j]),
            .i_new    (i_item.data),
            .i_next   (w_a_next[j]),
            .o_bit    (w_a[j])
        );
    end

    // Line B: fed from the center tap, cell 0 holds the pixel two rows back
    for (genvar j = 0; j < LINE_B; j++) begin : g_line_b
        assign w_ins_b[j] = (i_width == WID_W'(j + 1));
        if (j == LINE_B - 1) begin : g_end
            assign w_b_next[j] = w_a[1];
        end else begin : g_mid
            assign w_b_next[j] = w_b[j + 1];
        end
        bmc_cell u_cell (
            .i_clk    (i_clk),
            .i_shift  (w_push),
            .i_insert (w_ins_b[j]),
            .i_new    (w_a[1]),
            .i_next   (w_b_next[j]),
            .o_bit    (w_b[j])
        );
    end

    // Frame position of the incoming item and acceptance
    always_comb begin
        w_col_inc  = WID_W'(r_col) + WID_W'(1);
        w_row_end  = (w_col_inc == i_width);
        w_h_ext    = ROW_W'(i_height);
        w_filling  = (r_row < w_h_ext);
        w_draining = (r_row == w_h_ext);
        w_push     = (i_item.data_valid & w_filling) | (i_item.flush_valid & w_draining);
    end

    // Cross window one row behind the incoming item; out-of-frame neighbors drop out
    always_comb begin
        w_left_ok  = (r_col != '0);
        w_right_ok = !w_row_end;
        w_up_ok    = (r_row >= ROW_W'(2));
        w_below_ok = w_filling;
        w_ero = w_a[1] & (w_a[0] | !w_left_ok) & (w_a[2] | !w_right_ok)
              & (w_b[0] | !w_up_ok) & (i_item.data | !w_below_ok);
        w_dil = w_a[1] | (w_a[0] & w_left_ok) | (w_a[2] & w_right_ok)
              | (w_b[0] & w_up_ok) | (i_item.data & w_below_ok);
    end

    // Result of this push
    always_comb begin
        o_res.produce = w_push & (r_row != '0);
        o_res.value   = i_dilate ? w_dil : w_ero;
        o_res.last    = w_draining & w_row_end;
        o_res.done    = (r_row > w_h_ext);
    end

    // Advance the raster counter
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (w_push) begin
            if (w_row_end) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

>>> rtl/bmc_outq.sv
// Two-entry result queue between the filter stages and the output channel.
module bmc_outq
    import bmc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    input  logic    i_stall,
    output logic    o_full,
    output logic    o_valid,
    output t_result o_res
);

    t_result                r_ent [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0]  r_wptr;
    logic [OUTQ_PTR_W-1:0]  n_wptr;
    logic [OUTQ_PTR_W-1:0]  r_rptr;
    logic [OUTQ_PTR_W-1:0]  n_rptr;
    logic [OUTQ_CNT_W-1:0]  r_count;
    logic [OUTQ_CNT_W-1:0]  n_count;
    logic                   w_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == OUTQ_CNT_W'(OUTQ_DEPTH));
    assign o_res   = r_ent[r_rptr];
    assign w_pop   = o_valid & !i_stall;

    // Pointer and fill bookkeeping
    always_comb begin
        n_wptr  = i_push ? r_wptr + OUTQ_PTR_W'(1) : r_wptr;
        n_rptr  = w_pop ? r_rptr + OUTQ_PTR_W'(1) : r_rptr;
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + OUTQ_CNT_W'(1);
        end else if (!i_push && w_pop) begin
            n_count = r_count - OUTQ_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    // Store the entry
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wptr] <= i_res;
        end
    end

endmodule

>>> rtl/binary_morphology_cross.sv
// Top level: register block, two cascaded cross-filter stages and the result queue.
// Streams a binary frame in raster order, one pixel per transaction, and returns erosion,
// dilation, opening or closing with a plus-shaped 3x3 element. One transaction is taken
// every cycle unless stalled: the stages it feeds advance their cell chains in the cycle
// it is accepted, and its result, if any, is queued. Input stall rises only while the
// two-entry result queue is full. Results trail the input by one row (erosion, dilation)
// or two rows (opening, closing); at the end of a frame send flush transactions to drain
// them, one result per flush, with frame_last marking the final pixel. Any write to a
// listed register restarts the frame; pixels sent after a frame is complete are dropped
// until it has drained. Write configuration only while the block is idle.
module binary_morphology_cross
    import bmc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic                  i_pixel_in,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_pixel_out,
    output logic                  o_frame_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [WID_W-1:0]  r_width;
    logic [WID_W-1:0]  n_width;
    logic [HGT_W-1:0]  r_height;
    logic [HGT_W-1:0]  n_height;
    logic [MODE_W-1:0] r_mode;
    logic [MODE_W-1:0] n_mode;

    logic       w_cfg_wr;
    logic       w_cfg_hit;
    logic       w_accept;
    logic       w_dil1;
    logic       w_dil2;
    logic       w_two;
    logic       w_restart;
    logic       w_full;
    t_stage_in  w_s1_in;
    t_stage_in  w_s2_in;
    t_stage_out w_s1;
    t_stage_out w_s2;
    t_stage_out w_res;
    t_result    w_push_res;
    t_result    w_q_res;

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid & o_cfg_ready;
    assign w_accept    = i_in_valid & !o_in_stall;

    // Register writes
    always_comb begin
        n_width   = r_width;
        n_height  = r_height;
        n_mode    = r_mode;
        w_cfg_hit = w_cfg_wr && (i_cfg_index inside {CFG_WIDTH, CFG_HEIGHT, CFG_MODE});
        if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_WIDTH:  n_width  = clamp_width(i_cfg_data);
                CFG_HEIGHT: n_height = clamp_height(i_cfg_data);
                CFG_MODE:   n_mode   = i_cfg_data[MODE_W-1:0];
                default:    n_mode   = r_mode;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WID_W'(MAX_WIDTH);
            r_height <= HGT_W'(MAX_HEIGHT);
            r_mode   <= MODE_ERODE;
        end else begin
            r_width  <= n_width;
            r_height <= n_height;
            r_mode   <= n_mode;
        end
    end

    // Decode the operation
    always_comb begin
        w_dil1 = (r_mode == MODE_DILATE) || (r_mode == MODE_CLOSE);
        w_dil2 = (r_mode == MODE_OPEN);
        w_two  = (r_mode == MODE_OPEN) || (r_mode == MODE_CLOSE);
    end

    // Route transactions: pixels feed stage one, flushes go on once stage one has drained
    always_comb begin
        w_s1_in.data_valid  = w_accept & (i_req_type == REQ_PIXEL);
        w_s1_in.flush_valid = w_accept & (i_req_type == REQ_FLUSH);
        w_s1_in.data        = i_pixel_in;
        w_s2_in.data_valid  = w_two & w_s1.produce;
        w_s2_in.flush_valid = w_two & w_accept & (i_req_type == REQ_FLUSH) & w_s1.done;
        w_s2_in.data        = w_s1.value;
    end

    bmc_stage u_stage1 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_restart),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_dilate  (w_dil1),
        .i_item    (w_s1_in),
        .o_res     (w_s1)
    );

    bmc_stage u_stage2 (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_restart (w_restart),
        .i_width   (r_width),
        .i_height  (r_height),
        .i_dilate  (w_dil2),
        .i_item    (w_s2_in),
        .o_res     (w_s2)
    );

    // Pick the final stage and restart the frame on a register write or after its last pixel
    always_comb begin
        w_res            = w_two ? w_s2 : w_s1;
        w_restart        = w_cfg_hit | (w_res.produce & w_res.last);
        w_push_res.pixel = w_res.value;
        w_push_res.last  = w_res.last;
    end

    bmc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res.produce),
        .i_res   (w_push_res),
        .i_stall (i_out_stall),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .o_res   (w_q_res)
    );

    assign o_in_stall   = w_full;
    assign o_pixel_out  = w_q_res.pixel;
    assign o_frame_last = w_q_res.last;

    // A result only comes from an accepted transaction
    a_result_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_res.produce |-> w_accept)
        else $error("result without an accepted transaction");

    // The second stage only moves on first-stage data or once the first stage has drained
    a_stage2_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s2.produce |-> (w_s1.produce || w_s1.done))
        else $error("second stage result without a source");

    // After the last pixel of a frame both stages start over
    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_res.produce && w_res.last) |=> (!w_s1.done && !w_s2.done
            && !(w_res.produce && w_res.last)))
        else $error("frame did not restart after its last pixel");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the plus-shaped 3x3 binary morphology filter.
`timescale 1ns / 100ps

module tb_top;
    import bmc_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int SETTLE_CYCLES = 4;      // quiet cycles once the last result is out
    localparam int DRAIN_LIMIT   = 20000;
    localparam int RANDOM_ITEMS  = 1900;
    localparam int PRINT_LIMIT   = 50;

    // Index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef enum logic [1:0] {ROW_CFG, ROW_PIXEL, ROW_FLUSH} t_row_kind;

    // One line of the directed table; value is register data or the pixel in bit 0
    typedef struct {
        t_row_kind              kind;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  value;
        bit                     typed;
        bit                     exp_pixel;
        bit                     exp_last;
    } t_stim_row;

    typedef struct {
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  value;
    } t_reg_write;

    localparam int DIRECTED_ROWS = 34;

    // Pixel and flush rows carry CFG_WIDTH as a don't-care index
    t_stim_row directed [DIRECTED_ROWS] = '{
        '{ROW_CFG,   CFG_UNUSED, 9'h1FF,                   1'b0, 1'b0, 1'b0},
        '{ROW_CFG,   CFG_WIDTH,  9'd1,                     1'b0, 1'b0, 1'b0},
        '{ROW_CFG,   CFG_HEIGHT, 9'd1,                     1'b0, 1'b0, 1'b0},
        '{ROW_CFG,   CFG_MODE,   CFG_DATA_W'(MODE_ERODE),  1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_WIDTH,  9'd1,                     1'b0, 1'b0, 1'b0},
        '{ROW_FLUSH, CFG_WIDTH,  9'd0,                     1'b1, 1'b1, 1'b1},
        '{ROW_PIXEL, CFG_WIDTH,  9'd0,                     1'b0, 1'b0, 1'b0},
        '{ROW_FLUSH, CFG_WIDTH,  9'd1,                     1'b1, 1'b0, 1'b1},
        '{ROW_FLUSH, CFG_WIDTH,  9'd0,                     1'b0, 1'b0, 1'b0},
        '{ROW_CFG,   CFG_MODE,   CFG_DATA_W'(MODE_DILATE), 1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_WIDTH,  9'd1,                     1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_WIDTH,  9'd0,                     1'b0, 1'b0, 1'b0},
        '{ROW_FLUSH, CFG_WIDTH,  9'd0,                     1'b1, 1'b1, 1'b1},
        '{ROW_CFG,   CFG_WIDTH,  9'd0,                     1'b0, 1'b0, 1'b0},
        '{ROW_CFG,   CFG_HEIGHT, 9'd0,                     1'b0, 1'b0, 1'b0},
        '{ROW_CFG,   CFG_MODE,   CFG_DATA_W'(MODE_OPEN),   1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_WIDTH,  9'd1,                     1'b0, 1'b0, 1'b0},
        '{ROW_FLUSH, CFG_WIDTH,  9'd0,                     1'b0, 1'b0, 1'b0},
        '{ROW_FLUSH, CFG_WIDTH,  9'd0,                     1'b1, 1'b1, 1'b1},
        '{ROW_CFG,   CFG_WIDTH,  9'd3,                     1'b0, 1'b0, 1'b0},
        '{ROW_CFG,   CFG_HEIGHT, 9'd2,                     1'b0, 1'b0, 1'b0},
        '{ROW_CFG,   CFG_MODE,   CFG_DATA_W'(MODE_CLOSE),  1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_WIDTH,  9'd1,                     1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_WIDTH,  9'd0,                     1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_WIDTH,  9'd1,                     1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_WIDTH,  9'd0,                     1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_WIDTH,  9'd1,                     1'b0, 1'b0, 1'b0},
        '{ROW_PIXEL, CFG_WIDTH,  9'd1,                     1'b0, 1'b0, 1'b0},
        '{ROW_FLUSH, CFG_WIDTH,  9'd1,                     1'b0, 1'b0, 1'b0},
        '{ROW_FLUSH, CFG_WIDTH,  9'd0,                     1'b0, 1'b0, 1'b0},
        '{ROW_FLUSH, CFG_WIDTH,  9'd1,                     1'b0, 1'b0, 1'b0},
        '{ROW_FLUSH, CFG_WIDTH,  9'd0,                     1'b0, 1'b0, 1'b0},
        '{ROW_FLUSH, CFG_WIDTH,  9'd1,                     1'b0, 1'b0, 1'b0},
        '{ROW_FLUSH, CFG_WIDTH,  9'd0,                     1'b0, 1'b0, 1'b0}
    };

    // DUT ports
    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    logic                  o_in_stall;
    logic                  i_req_type   = REQ_PIXEL;
    logic                  i_pixel_in   = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall  = 1'b0;
    logic                  o_pixel_out;
    logic                  o_frame_last;
    logic                  i_cfg_valid  = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index  = CFG_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;

    // Filter state as the testbench sees it
    bit                    line_in  [2*MAX_WIDTH];  // input pixels, two rows
    bit                    line_mid [2*MAX_WIDTH];  // first-stage results, two rows
    int unsigned           in_col, in_row, mid_pos, out_pos;
    logic [CFG_DATA_W-1:0] reg_width, reg_height;
    logic [MODE_W-1:0]     reg_mode;

    t_result               expected_q [$];
    t_reg_write            reg_plan [$];
    int unsigned           mismatch_count = 0;
    int unsigned           items_sent = 0;
    bit                    gaps_on = 1'b1;

    // Typed expectation that travels with the transaction on the input port
    bit                    row_typed = 1'b0;
    t_result               row_result = '0;

    binary_morphology_cross i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_pixel_in   (i_pixel_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_out  (o_pixel_out),
        .o_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) begin
            $display("%0t ns: mismatch: %s", $time, what);
        end
    endtask

    // Zero reads as one, large values saturate
    function automatic int unsigned eff_dim(logic [CFG_DATA_W-1:0] v, int unsigned lim);
        if (v == '0) return 1;
        if (32'(v) > lim) return lim;
        return 32'(v);
    endfunction

    function automatic void restart_counts();
        in_col  = 0;
        in_row  = 0;
        mid_pos = 0;
        out_pos = 0;
    endfunction

    function automatic bit stored_bit(bit second, int unsigned idx);
        return second ? line_mid[idx] : line_in[idx];
    endfunction

    function automatic bit fold(bit acc, bit x, bit dilate);
        return dilate ? (acc | x) : (acc & x);
    endfunction

    // Cross filter at raster position pos; below is the pixel one row down when known
    function automatic bit plus_filter(bit second, int unsigned pos, int unsigned w,
                                       int unsigned h, bit has_below, bit below, bit dilate);
        int unsigned r, c, base;
        bit acc;
        r    = pos / w;
        c    = pos % w;
        base = (r & 1) * MAX_WIDTH;
        acc  = stored_bit(second, base + c);
        if (c > 0) acc = fold(acc, stored_bit(second, base + c - 1), dilate);
        if (c + 1 < w) acc = fold(acc, stored_bit(second, base + c + 1), dilate);
        if (r > 0) acc = fold(acc, stored_bit(second, ((r - 1) & 1) * MAX_WIDTH + c), dilate);
        if (has_below && r + 1 < h) acc = fold(acc, below, dilate);
        return acc;
    endfunction

    // Advance both stages by one input transaction and return the result it causes
    function automatic void predict_item(logic req, logic pix, output bit hit,
                                         output t_result res);
        int unsigned w, h, total, p1, p2, col;
        bit dil1, dil2, cascade, full, s1, s2, v1, v2;
        w       = eff_dim(reg_width, MAX_WIDTH);
        h       = eff_dim(reg_height, MAX_HEIGHT);
        total   = w * h;
        dil1    = (reg_mode == MODE_DILATE || reg_mode == MODE_CLOSE);
        dil2    = (reg_mode == MODE_OPEN);
        cascade = (reg_mode == MODE_OPEN || reg_mode == MODE_CLOSE);
        full    = (in_row >= h);
        p1      = mid_pos;
        s1      = 1'b0;
        v1      = 1'b0;
        hit     = 1'b0;
        res     = '0;
        if (req == REQ_PIXEL) begin
            if (full) return;
            col = (in_col < w) ? in_col : w - 1;
            if (in_row * w + col >= w) begin
                s1 = 1'b1;
                v1 = plus_filter(1'b0, p1, w, h, 1'b1, pix, dil1);
            end
            line_in[(in_row & 1) * MAX_WIDTH + col] = pix;
            in_col = col + 1;
            if (in_col >= w) begin
                in_col = 0;
                in_row++;
            end
        end else begin
            if (!full) return;
            if (p1 < total) begin
                s1 = 1'b1;
                v1 = plus_filter(1'b0, p1, w, h, 1'b0, 1'b0, dil1);
            end
        end

        // single stage: the first-stage value is the result
        if (!cascade) begin
            if (!s1) return;
            hit       = 1'b1;
            res.pixel = v1;
            res.last  = (p1 + 1 == total);
            mid_pos   = p1 + 1;
            out_pos   = p1 + 1;
            if (p1 + 1 >= total) restart_counts();
            return;
        end

        // cascade: feed the first-stage value into the second stage
        p2 = out_pos;
        s2 = 1'b0;
        v2 = 1'b0;
        if (s1) begin
            if (p1 >= w) begin
                s2 = 1'b1;
                v2 = plus_filter(1'b1, p2, w, h, 1'b1, v1, dil2);
            end
            line_mid[((p1 / w) & 1) * MAX_WIDTH + (p1 % w)] = v1;
            mid_pos = p1 + 1;
        end else if (full && p1 >= total && p2 < total) begin
            s2 = 1'b1;
            v2 = plus_filter(1'b1, p2, w, h, 1'b0, 1'b0, dil2);
        end
        if (!s2) return;
        hit       = 1'b1;
        res.pixel = v2;
        res.last  = (p2 + 1 == total);
        out_pos   = p2 + 1;
        if (p2 + 1 >= total) restart_counts();
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] val);
        case (idx)
            CFG_WIDTH:  reg_width  = val;
            CFG_HEIGHT: reg_height = val;
            CFG_MODE:   reg_mode   = val[MODE_W-1:0];
            default:    return;
        endcase
        restart_counts();
    endfunction

    // Check results, then predict accepted inputs and track register writes
    always @(posedge i_clk) begin
        bit      hit;
        t_result res;
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result pixel=%0b last=%0b",
                                              o_pixel_out, o_frame_last));
                end else begin
                    want = expected_q.pop_front();
                    if (o_pixel_out !== want.pixel) begin
                        report_mismatch($sformatf("pixel_out %0b, expected %0b",
                                                  o_pixel_out, want.pixel));
                    end
                    if (o_frame_last !== want.last) begin
                        report_mismatch($sformatf("frame_last %0b, expected %0b",
                                                  o_frame_last, want.last));
                    end
                end
            end
            if (i_in_valid && !o_in_stall) begin
                predict_item(i_req_type, i_pixel_in, hit, res);
                if (row_typed) begin
                    expected_q.push_back(row_result);
                end else if (hit) begin
                    expected_q.push_back(res);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                apply_register(i_cfg_index, i_cfg_data);
            end
        end
    end

    // Output back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= gaps_on && ($urandom_range(99) < 32);
    end

    // Offer one transaction, with an optional gap ahead of it, and hold until taken
    task automatic send_item(logic req, logic pix, bit typed = 1'b0, t_result res = '0);
        if (gaps_on && $urandom_range(99) < 32) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 32);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_pixel_in <= pix;
        row_typed  <= typed;
        row_result <= res;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Wait for every pending result, then let the pipeline go quiet
    task automatic settle();
        int unsigned n;
        n = 0;
        do begin
            @(posedge i_clk);
            n++;
        end while (expected_q.size() != 0 && n < DRAIN_LIMIT);
        if (expected_q.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_q.size()));
            expected_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Drain the block, then issue the planned register writes back to back
    task automatic write_registers();
        t_reg_write wr;
        i_in_valid <= 1'b0;
        settle();
        while (reg_plan.size() != 0) begin
            wr = reg_plan.pop_front();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= wr.index;
            i_cfg_data  <= wr.value;
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int unsigned           phase, frames, w, h, total, drain, cut, density;
        logic [CFG_DATA_W-1:0] new_w, new_h;
        bit                    noisy, cut_short, fixed_shape;
        t_result               typed_res;

        // Reset state of the filter
        foreach (line_in[i]) line_in[i] = 1'b0;
        foreach (line_mid[i]) line_mid[i] = 1'b0;
        reg_width  = 9'd256;
        reg_height = 9'd256;
        reg_mode   = MODE_ERODE;
        restart_counts();

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table: group adjacent register rows into one write burst
        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (directed[i].kind == ROW_CFG) begin
                reg_plan.push_back(t_reg_write'{directed[i].index, directed[i].value});
                if (i + 1 == DIRECTED_ROWS || directed[i + 1].kind != ROW_CFG) begin
                    write_registers();
                end
            end else begin
                typed_res = {directed[i].exp_pixel, directed[i].exp_last};
                send_item(directed[i].kind == ROW_FLUSH ? REQ_FLUSH : REQ_PIXEL,
                          directed[i].value[0], directed[i].typed, typed_res);
            end
        end

        // Random phases: new settings, then a few frames each
        phase = 0;
        while (items_sent < RANDOM_ITEMS) begin
            fixed_shape = 1'b1;
            frames      = 1;
            case (phase)
                3: begin
                    new_w = 9'h1FF;
                    new_h = 9'd2;
                end
                8: begin
                    new_w = 9'd1;
                    new_h = 9'h1FF;
                end
                default: begin
                    fixed_shape = 1'b0;
                    frames      = $urandom_range(1, 3);
                    new_w       = CFG_DATA_W'($urandom_range(0, 8));
                    new_h       = CFG_DATA_W'($urandom_range(0, 6));
                end
            endcase
            if (fixed_shape || $urandom_range(99) < 70) begin
                reg_plan.push_back(t_reg_write'{CFG_WIDTH, new_w});
            end
            if (fixed_shape || $urandom_range(99) < 70) begin
                reg_plan.push_back(t_reg_write'{CFG_HEIGHT, new_h});
            end
            // keep the full-width frame single stage so its drain stays one row
            if (phase == 3) begin
                reg_plan.push_back(t_reg_write'{CFG_MODE, $urandom_range(1) ?
                                   CFG_DATA_W'(MODE_DILATE) : CFG_DATA_W'(MODE_ERODE)});
            end else if (reg_plan.size() == 0 || $urandom_range(99) < 70) begin
                reg_plan.push_back(t_reg_write'{CFG_MODE, CFG_DATA_W'($urandom)});
            end
            if ($urandom_range(99) < 20) begin
                reg_plan.push_back(t_reg_write'{CFG_UNUSED, CFG_DATA_W'($urandom)});
            end
            write_registers();
            phase++;

            cut_short = 1'b0;
            repeat (frames) begin
                if (!cut_short) begin
                    w       = eff_dim(reg_width, MAX_WIDTH);
                    h       = eff_dim(reg_height, MAX_HEIGHT);
                    total   = w * h;
                    drain   = (reg_mode == MODE_OPEN || reg_mode == MODE_CLOSE) ? 2 * w : w;
                    density = $urandom_range(10, 90);
                    noisy   = !fixed_shape && ($urandom_range(99) < 15);
                    cut     = (noisy && $urandom_range(3) == 0) ?
                              $urandom_range(total - 1) : total;

                    // pixels of the frame; noisy frames slip in early flushes
                    for (int k = 0; k < cut; k++) begin
                        if (noisy && $urandom_range(99) < 20) begin
                            send_item(REQ_FLUSH, $urandom_range(1));
                        end
                        send_item(REQ_PIXEL, $urandom_range(99) < density);
                        items_sent++;
                    end

                    // a cut frame is abandoned; the next register write restarts it
                    if (cut < total) begin
                        cut_short = 1'b1;
                    end else begin
                        for (int k = 0; k < drain; k++) begin
                            if (noisy && $urandom_range(99) < 20) begin
                                send_item(REQ_PIXEL, $urandom_range(1));
                            end
                            send_item(REQ_FLUSH, $urandom_range(1));
                            items_sent++;
                        end
                        if (noisy && $urandom_range(1)) begin
                            send_item(REQ_FLUSH, $urandom_range(1));
                        end
                    end
                end
            end
            // hold a stretch with no gaps on either side
            gaps_on <= !(items_sent >= 700 && items_sent < 1100);
        end

        i_in_valid <= 1'b0;
        settle();
        if (mismatch_count == 0) begin
            $display("[binary_morphology_cross] OK");
        end else begin
            $display("[binary_morphology_cross] ERROR");
        end
        $finish;
    end

    // Run limit
    initial begin
        #2000000;
        $display("[binary_morphology_cross] ERROR");
        $finish;
    end

endmodule
